[sv/ilsc_pkg.sv]
// Package for the interval list section cutter.
// Holds field widths, request codes and register indexes; no dependencies.
`default_nettype none

package ilsc_pkg;

   // Field widths.
   localparam int ADDR_W   = 32;
   localparam int LEN_W    = 32;
   localparam int COUNT_W  = 6;
   localparam int SLOT_W   = 5;
   localparam int OFF_W    = 33;
   localparam int REGION_W = 32;
   localparam int ENTRY_W  = 2 * ADDR_W;

   // Request function codes.
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_CUT  = 1'b1;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECTION_LENGTH = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTERVAL_COUNT = 1'b1;

endpackage

`default_nettype wire

[sv/ilsc_ram.sv]
// Generic single write port, single read port RAM with a registered read.
// Standalone; used for the interval table of the section cutter.
`default_nettype none

module ilsc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/interval_list_section_cutter_unit.sv]
// Top level of the interval list section cutter: sequencer, step unit and table.
// Depends on ilsc_pkg (widths, codes) and ilsc_ram (interval table).
//
//   Channel   Handshake          Payload
//   request   start / busy       req_func, req_slot, req_interval_begin, req_interval_end
//   response  rsp_strobe         rsp_piece_begin, rsp_piece_end, rsp_piece_valid,
//                                rsp_last_piece, rsp_region_number
//   config    csr_wr_en          csr_index, csr_wr_data
//
// A load request gives no response. A cut request walks the table twice through one
// step unit at one entry per cycle: a counting pass, then an emitting pass over the
// same entries. The table read port sets that pace. Responses come one per cycle
// during the emitting pass and cannot be held off by the receiver. Reset is
// synchronous; the table holds no reset value until loaded.
`default_nettype none

module interval_list_section_cutter_unit #(
   parameter int TABLE_DEPTH = 32
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   // Request channel
   input  wire logic                                    start,
   output      logic                                    busy,
   input  wire logic                                    req_func,
   input  wire logic [ilsc_pkg::SLOT_W-1:0]             req_slot,
   input  wire logic [ilsc_pkg::ADDR_W-1:0]             req_interval_begin,
   input  wire logic [ilsc_pkg::ADDR_W-1:0]             req_interval_end,
   // Response channel
   output      logic                                    rsp_strobe,
   output      logic [ilsc_pkg::ADDR_W-1:0]             rsp_piece_begin,
   output      logic [ilsc_pkg::ADDR_W-1:0]             rsp_piece_end,
   output      logic                                    rsp_piece_valid,
   output      logic                                    rsp_last_piece,
   output      logic [ilsc_pkg::REGION_W-1:0]           rsp_region_number,
   // Configuration port
   input  wire logic                                    csr_wr_en,
   input  wire logic [ilsc_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  wire logic [ilsc_pkg::LEN_W-1:0]              csr_wr_data
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COUNT,
      ST_EMIT
   } state_type;

   // Registers.
   state_type                           state_ff, state_in;
   logic [ilsc_pkg::LEN_W-1:0]          section_length_ff, section_length_in;
   logic [ilsc_pkg::COUNT_W-1:0]        interval_count_ff, interval_count_in;
   logic [ilsc_pkg::COUNT_W-1:0]        pos_ff, pos_in;
   logic [ilsc_pkg::OFF_W-1:0]          offset_ff, offset_in;
   logic [ilsc_pkg::REGION_W-1:0]       region_ff, region_in;
   logic [ilsc_pkg::COUNT_W-1:0]        walk_pos_ff, walk_pos_in;
   logic [ilsc_pkg::OFF_W-1:0]          walk_off_ff, walk_off_in;
   logic                                walk_first_ff, walk_first_in;
   logic [ilsc_pkg::COUNT_W-1:0]        pieces_ff, pieces_in;
   logic [ilsc_pkg::COUNT_W-1:0]        emitted_ff, emitted_in;
   logic                                rsp_strobe_ff, rsp_strobe_in;
   logic [ilsc_pkg::ADDR_W-1:0]         rsp_begin_ff, rsp_begin_in;
   logic [ilsc_pkg::ADDR_W-1:0]         rsp_end_ff, rsp_end_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_last_ff, rsp_last_in;

   // Table port signals.
   logic                                tbl_wr_en;
   logic [AW-1:0]                       tbl_wr_addr;
   logic [ilsc_pkg::ENTRY_W-1:0]        tbl_wr_data;
   logic [AW-1:0]                       tbl_rd_addr;
   logic [ilsc_pkg::ENTRY_W-1:0]        tbl_rd_data;

   // Step unit signals.
   logic [ilsc_pkg::COUNT_W-1:0]        count;
   logic [ilsc_pkg::ADDR_W-1:0]         ent_begin;
   logic [ilsc_pkg::ADDR_W-1:0]         ent_end;
   logic [ilsc_pkg::OFF_W-1:0]          ent_size;
   logic [ilsc_pkg::OFF_W-1:0]          start_off;
   logic [ilsc_pkg::OFF_W-1:0]          clip_start;
   logic                                pos_ok;
   logic                                step_full;
   logic                                step_part;
   logic [ilsc_pkg::ADDR_W-1:0]         piece_begin;
   logic [ilsc_pkg::OFF_W-1:0]          section_off;
   logic                                accept;

   assign accept = start && (state_ff == ST_IDLE);

   // Effective entry count, limited to the table depth.
   assign count = (32'(interval_count_ff) > TABLE_DEPTH) ?
                  ilsc_pkg::COUNT_W'(TABLE_DEPTH) : interval_count_ff;

   // Table loads happen only while idle.
   assign tbl_wr_en   = accept && (req_func == ilsc_pkg::FUNC_LOAD) &&
                        (32'(req_slot) < TABLE_DEPTH);
   assign tbl_wr_addr = AW'(req_slot);
   assign tbl_wr_data = {req_interval_begin, req_interval_end};
   // The read address follows the next walk position, so the data lines up with it.
   assign tbl_rd_addr = AW'(walk_pos_in);

   ilsc_ram #(
      .WIDTH (ilsc_pkg::ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   // Shared step unit: sizes the current entry and decides whole or partial piece.
   assign ent_begin   = tbl_rd_data[ilsc_pkg::ENTRY_W-1:ilsc_pkg::ADDR_W];
   assign ent_end     = tbl_rd_data[ilsc_pkg::ADDR_W-1:0];
   assign ent_size    = (ent_end >= ent_begin) ?
                        {1'b0, ent_end - ent_begin} : '0;
   assign start_off   = walk_first_ff ? offset_ff : '0;
   assign clip_start  = (start_off > ent_size) ? ent_size : start_off;
   assign pos_ok      = walk_pos_ff < count;
   assign step_full   = pos_ok && (walk_off_ff >= ent_size);
   assign step_part   = pos_ok && !step_full && (walk_off_ff != '0);
   assign piece_begin = ent_begin + clip_start[ilsc_pkg::ADDR_W-1:0];
   assign section_off = offset_ff + ilsc_pkg::OFF_W'(section_length_ff);

   // Sequencer next-state logic.
   always_comb begin
      state_in          = state_ff;
      section_length_in = section_length_ff;
      interval_count_in = interval_count_ff;
      pos_in            = pos_ff;
      offset_in         = offset_ff;
      region_in         = region_ff;
      walk_pos_in       = walk_pos_ff;
      walk_off_in       = walk_off_ff;
      walk_first_in     = walk_first_ff;
      pieces_in         = pieces_ff;
      emitted_in        = emitted_ff;
      rsp_strobe_in     = 1'b0;
      rsp_begin_in      = rsp_begin_ff;
      rsp_end_in        = rsp_end_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_last_in       = rsp_last_ff;

      // Configuration writes.
      if (csr_wr_en) begin
         unique case (csr_index)
            ilsc_pkg::CSR_SECTION_LENGTH: section_length_in = csr_wr_data;
            ilsc_pkg::CSR_INTERVAL_COUNT:
               interval_count_in = csr_wr_data[ilsc_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            walk_pos_in = pos_ff;
            if (accept && (req_func == ilsc_pkg::FUNC_CUT)) begin
               walk_off_in   = section_off;
               walk_first_in = 1'b1;
               pieces_in     = '0;
               state_in      = ST_COUNT;
            end
         end

         // Counting pass: find the number of pieces and whether the table wraps.
         ST_COUNT: begin
            if (step_full) begin
               walk_pos_in   = walk_pos_ff + ilsc_pkg::COUNT_W'(1);
               walk_off_in   = walk_off_ff - ent_size;
               walk_first_in = 1'b0;
               pieces_in     = pieces_ff + ilsc_pkg::COUNT_W'(1);
            end else begin
               pieces_in     = pieces_ff + ilsc_pkg::COUNT_W'(step_part);
               region_in     = region_ff + ilsc_pkg::REGION_W'(!pos_ok);
               walk_pos_in   = pos_ff;
               walk_off_in   = section_off;
               walk_first_in = 1'b1;
               emitted_in    = '0;
               state_in      = ST_EMIT;
            end
         end

         // Emitting pass: repeat the walk and send a piece for each whole or partial step.
         ST_EMIT: begin
            if (step_full) begin
               rsp_strobe_in = 1'b1;
               rsp_begin_in  = piece_begin;
               rsp_end_in    = ent_end;
               rsp_valid_in  = 1'b1;
               rsp_last_in   = (emitted_ff == pieces_ff - ilsc_pkg::COUNT_W'(1));
               emitted_in    = emitted_ff + ilsc_pkg::COUNT_W'(1);
               walk_pos_in   = walk_pos_ff + ilsc_pkg::COUNT_W'(1);
               walk_off_in   = walk_off_ff - ent_size;
               walk_first_in = 1'b0;
            end else begin
               if (step_part) begin
                  rsp_strobe_in = 1'b1;
                  rsp_begin_in  = piece_begin;
                  rsp_end_in    = ent_begin + walk_off_ff[ilsc_pkg::ADDR_W-1:0];
                  rsp_valid_in  = 1'b1;
                  rsp_last_in   = 1'b1;
               end else if (pieces_ff == '0) begin
                  // Empty section: a single marker response.
                  rsp_strobe_in = 1'b1;
                  rsp_begin_in  = '0;
                  rsp_end_in    = '0;
                  rsp_valid_in  = 1'b0;
                  rsp_last_in   = 1'b1;
               end
               // Commit the new position; running off the table restarts it.
               pos_in      = pos_ok ? walk_pos_ff : '0;
               offset_in   = pos_ok ? walk_off_ff : '0;
               walk_pos_in = pos_ok ? walk_pos_ff : '0;
               state_in    = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         section_length_ff <= ilsc_pkg::LEN_W'(1);
         interval_count_ff <= '0;
         pos_ff            <= '0;
         offset_ff         <= '0;
         region_ff         <= '0;
         walk_pos_ff       <= '0;
         rsp_strobe_ff     <= 1'b0;
      end else begin
         state_ff          <= state_in;
         section_length_ff <= section_length_in;
         interval_count_ff <= interval_count_in;
         pos_ff            <= pos_in;
         offset_ff         <= offset_in;
         region_ff         <= region_in;
         walk_pos_ff       <= walk_pos_in;
         rsp_strobe_ff     <= rsp_strobe_in;
      end
      walk_off_ff   <= walk_off_in;
      walk_first_ff <= walk_first_in;
      pieces_ff     <= pieces_in;
      emitted_ff    <= emitted_in;
      rsp_begin_ff  <= rsp_begin_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_valid_ff  <= rsp_valid_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_piece_begin   = rsp_begin_ff;
   assign rsp_piece_end     = rsp_end_ff;
   assign rsp_piece_valid   = rsp_valid_ff;
   assign rsp_last_piece    = rsp_last_ff;
   assign rsp_region_number = region_ff;

endmodule

`default_nettype wire

[bench/ilsc_tb_pkg.sv]
// Scoreboard for the interval list section cutter bench: a behavioural model of
// the interval table and cut position, plus the queue of awaited pieces.
// Depends on ilsc_pkg for request codes and register indexes.
package ilsc_tb_pkg;

   import ilsc_pkg::*;

   localparam int TABLE_DEPTH = 32;

   typedef struct packed {
      logic [31:0] piece_begin;
      logic [31:0] piece_end;
      logic        piece_valid;
      logic        last_piece;
      logic [31:0] region_number;
   } piece_t;

   class piece_scoreboard;
      logic [31:0] entry_begin [TABLE_DEPTH];
      logic [31:0] entry_end [TABLE_DEPTH];
      logic [5:0]  cursor;
      logic [32:0] carry_offset;
      logic [31:0] region;
      logic [31:0] section_len;
      logic [5:0]  count_reg;
      piece_t      awaited_pieces[$];
      int unsigned errors, loads, cuts, results, empties, wraps;

      function new();
         foreach (entry_begin[i]) begin
            entry_begin[i] = '0;
            entry_end[i] = '0;
         end
         cursor = '0;
         carry_offset = '0;
         region = '0;
         section_len = 32'd1;
         count_reg = '0;
         errors = 0;
         loads = 0;
         cuts = 0;
         results = 0;
         empties = 0;
         wraps = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index, logic [31:0] data);
         if (index == CSR_SECTION_LENGTH) begin
            section_len = data;
         end else if (index == CSR_INTERVAL_COUNT) begin
            count_reg = data[5:0];
         end
      endfunction

      // A reversed interval counts as empty.
      function logic [63:0] span(int unsigned i);
         if (entry_end[i] >= entry_begin[i]) begin
            return 64'(entry_end[i]) - 64'(entry_begin[i]);
         end
         return '0;
      endfunction

      function piece_t make_piece(logic [31:0] b, logic [31:0] e, logic v);
         piece_t p;
         p.piece_begin = b;
         p.piece_end = e;
         p.piece_valid = v;
         p.last_piece = 1'b0;
         p.region_number = '0;
         return p;
      endfunction

      // Called once per accepted request; a cut queues the pieces it will produce.
      function void note_request(logic func, logic [4:0] slot, logic [31:0] first,
                                 logic [31:0] past_end);
         piece_t      cut_pieces[$];
         int unsigned limit, pos;
         logic [63:0] start_at, reach, size, skip;
         if (func == FUNC_LOAD) begin
            entry_begin[slot] = first;
            entry_end[slot] = past_end;
            loads++;
         end else begin
            cuts++;
            limit = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : count_reg;
            pos = cursor;
            start_at = 64'(carry_offset);
            reach = start_at + 64'(section_len);
            // Whole intervals, or the remainder of the one the last cut stopped in.
            while (pos < limit && reach >= span(pos)) begin
               size = span(pos);
               skip = (start_at > size) ? size : start_at;
               reach -= size;
               cut_pieces.push_back(make_piece(entry_begin[pos] + skip[31:0],
                                               entry_end[pos], 1'b1));
               pos++;
               start_at = '0;
            end
            // Partial tail piece; a stale offset is held at the entry's end.
            if (pos < limit && reach != 0) begin
               size = span(pos);
               skip = (start_at > size) ? size : start_at;
               cut_pieces.push_back(make_piece(entry_begin[pos] + skip[31:0],
                                               entry_begin[pos] + reach[31:0], 1'b1));
            end
            // Table used up: drop what is left and start a new region.
            if (pos >= limit) begin
               region++;
               wraps++;
               pos = 0;
               reach = '0;
            end
            cursor = pos[5:0];
            carry_offset = reach[32:0];
            if (cut_pieces.size() == 0) begin
               cut_pieces.push_back(make_piece('0, '0, 1'b0));
               empties++;
            end
            foreach (cut_pieces[k]) cut_pieces[k].region_number = region;
            cut_pieces[cut_pieces.size()-1].last_piece = 1'b1;
            results += cut_pieces.size();
            awaited_pieces = {awaited_pieces, cut_pieces};
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            errors++;
         end
      endfunction

      function void check_piece(piece_t seen);
         piece_t want;
         if (awaited_pieces.size() == 0) begin
            $error("response with nothing awaited: begin %h end %h valid %b",
                   seen.piece_begin, seen.piece_end, seen.piece_valid);
            errors++;
         end else begin
            want = awaited_pieces.pop_front();
            compare_field("piece_begin", want.piece_begin, seen.piece_begin);
            compare_field("piece_end", want.piece_end, seen.piece_end);
            compare_field("piece_valid", 32'(want.piece_valid), 32'(seen.piece_valid));
            compare_field("last_piece", 32'(want.last_piece), 32'(seen.last_piece));
            compare_field("region_number", want.region_number, seen.region_number);
         end
      endfunction

      function void finish_check();
         if (awaited_pieces.size() != 0) begin
            $error("%0d awaited pieces never arrived", awaited_pieces.size());
            errors += awaited_pieces.size();
         end
      endfunction
   endclass

endpackage

[bench/tb_interval_list_section_cutter_unit.sv]
// Top-level bench for interval_list_section_cutter_unit: directed and random
// requests, register changes between phases, and piece-by-piece response checks.
// Depends on ilsc_pkg and ilsc_tb_pkg (scoreboard).
module tb_interval_list_section_cutter_unit;

   timeunit 1ns;
   timeprecision 1ps;

   import ilsc_pkg::*;
   import ilsc_tb_pkg::*;

   localparam int QUIET_CYCLES = 2 * TABLE_DEPTH + 4;

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_func = FUNC_LOAD;
   logic [4:0]  req_slot = '0;
   logic [31:0] req_interval_begin = '0;
   logic [31:0] req_interval_end = '0;
   logic        rsp_strobe;
   logic [31:0] rsp_piece_begin;
   logic [31:0] rsp_piece_end;
   logic        rsp_piece_valid;
   logic        rsp_last_piece;
   logic [31:0] rsp_region_number;
   logic        csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_SECTION_LENGTH;
   logic [31:0] csr_wr_data = '0;

   piece_scoreboard board = new();
   int unsigned     idle_pct = 0;

   interval_list_section_cutter_unit #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
      .clock(clock), .reset(reset),
      .start(start), .busy(busy),
      .req_func(req_func), .req_slot(req_slot),
      .req_interval_begin(req_interval_begin), .req_interval_end(req_interval_end),
      .rsp_strobe(rsp_strobe), .rsp_piece_begin(rsp_piece_begin),
      .rsp_piece_end(rsp_piece_end), .rsp_piece_valid(rsp_piece_valid),
      .rsp_last_piece(rsp_last_piece), .rsp_region_number(rsp_region_number),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Responses cannot be held off, so every strobe is checked as it comes.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         board.check_piece(piece_t'{rsp_piece_begin, rsp_piece_end, rsp_piece_valid,
                                    rsp_last_piece, rsp_region_number});
      end
   end

   // Present one request, hold it until accepted, then maybe leave a gap.
   task automatic issue(input logic func, input logic [4:0] slot,
                        input logic [31:0] first, input logic [31:0] past_end);
      start <= 1'b1;
      req_func <= func;
      req_slot <= slot;
      req_interval_begin <= first;
      req_interval_end <= past_end;
      do @(posedge clock); while (busy);
      board.note_request(func, slot, first, past_end);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every awaited piece is in and the block is quiet.
   task automatic drain_all();
      start <= 1'b0;
      while (board.awaited_pieces.size() != 0 || busy) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // Both registers are written back to back once the block is idle.
   task automatic write_settings(input logic [31:0] len, input logic [31:0] count_data);
      drain_all();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_SECTION_LENGTH;
      csr_wr_data <= len;
      @(posedge clock);
      board.write_register(CSR_SECTION_LENGTH, len);
      csr_index <= CSR_INTERVAL_COUNT;
      csr_wr_data <= count_data;
      @(posedge clock);
      board.write_register(CSR_INTERVAL_COUNT, count_data);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly short intervals, with reversed, random, full-range and zero-size ones.
   function automatic void pick_interval(output logic [31:0] b, output logic [31:0] e);
      int unsigned sel = $urandom_range(99);
      b = $urandom;
      if (sel < 65) begin
         e = b + $urandom_range(0, 24);
      end else if (sel < 75) begin
         e = b - $urandom_range(1, 1000);
      end else if (sel < 88) begin
         e = $urandom;
      end else if (sel < 94) begin
         b = '0;
         e = 32'hFFFF_FFFF;
      end else begin
         b = 32'hFFFF_FFFF;
         e = b;
      end
   endfunction

   initial begin
      logic [31:0] b, e, len, cnt;
      int unsigned sel;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part. With reset settings the count is zero: empty section and wrap.
      issue(FUNC_CUT, 5'h1F, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      write_settings(32'd5, 32'd6);
      issue(FUNC_LOAD, 5'd0, 32'h0000_0000, 32'h0000_0003);
      issue(FUNC_LOAD, 5'd1, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
      issue(FUNC_LOAD, 5'd2, 32'd100, 32'd100);
      issue(FUNC_LOAD, 5'd3, 32'd500, 32'd200);
      issue(FUNC_LOAD, 5'd4, 32'h8000_0000, 32'h8000_0008);
      issue(FUNC_LOAD, 5'd5, 32'h0000_0000, 32'hFFFF_FFFF);
      // Whole, partial and zero-size pieces, including a reversed entry.
      repeat (4) issue(FUNC_CUT, 5'd0, 32'd0, 32'd0);
      // Longest section: the second cut runs off the table end, and what is left of it is dropped.
      write_settings(32'hFFFF_FFFF, 32'd6);
      repeat (2) issue(FUNC_CUT, 5'h15, 32'hAAAA_AAAA, 32'h5555_5555);
      // Zero section length takes only the zero-size entry, then gives an empty section.
      issue(FUNC_LOAD, 5'd0, 32'd7, 32'd7);
      write_settings(32'd0, 32'd6);
      repeat (2) issue(FUNC_CUT, 5'h0A, 32'h5555_5555, 32'hAAAA_AAAA);
      // Rewrite the current entry shorter than the offset already reached.
      write_settings(32'd4, 32'd6);
      issue(FUNC_CUT, 5'd0, 32'd0, 32'd0);
      issue(FUNC_LOAD, 5'd1, 32'd50, 32'd52);
      issue(FUNC_CUT, 5'd0, 32'd0, 32'd0);
      // Count beyond the table depth, with high data bits that the register drops.
      write_settings(32'd4, 32'hFFFF_FFE3);
      issue(FUNC_CUT, 5'd0, 32'd0, 32'd0);

      // Fill the whole table so that no cut can reach an unwritten entry.
      drain_all();
      idle_pct = 22;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         pick_interval(b, e);
         issue(FUNC_LOAD, 5'(i), b, e);
      end

      // Random phases: sender gaps at 22 percent, then 58, then none.
      for (int seg = 0; seg < 10; seg++) begin
         idle_pct = (seg < 3) ? 22 : (seg < 6) ? 58 : 0;
         case (seg)
            0: begin
               len = 32'hFFFF_FFFF;
               cnt = 32'd32;
            end
            1: begin
               len = 32'd1;
               cnt = 32'd1;
            end
            2: begin
               len = 32'd0;
               cnt = 32'd32;
            end
            3: begin
               len = 32'd3;
               cnt = 32'd63;
            end
            default: begin
               sel = $urandom_range(99);
               if (sel < 30) len = $urandom_range(1, 8);
               else if (sel < 60) len = $urandom_range(9, 64);
               else if (sel < 70) len = 32'd0;
               else if (sel < 80) len = 32'hFFFF_FFFF;
               else if (sel < 90) len = $urandom;
               else len = $urandom_range(65, 400);
               sel = $urandom_range(99);
               if (sel < 10) cnt = 32'd0;
               else if (sel < 20) cnt = 32'd32;
               else if (sel < 30) cnt = {26'($urandom), 6'($urandom_range(33, 63))};
               else cnt = $urandom_range(1, 32);
            end
         endcase
         write_settings(len, cnt);
         repeat (26) begin
            if ($urandom_range(99) < 75) begin
               issue(FUNC_CUT, 5'($urandom), $urandom, $urandom);
            end else begin
               pick_interval(b, e);
               issue(FUNC_LOAD, 5'($urandom), b, e);
            end
            // Now and then the sender waits for every awaited piece.
            if ($urandom_range(99) < 3) drain_all();
         end
      end

      drain_all();
      $display("Covered %0d interval loads and %0d section cuts under %0d settings,",
               board.loads, board.cuts, 15);
      $display("giving %0d responses, %0d empty sections and %0d table wraps.",
               board.results, board.empties, board.wraps);
      board.finish_check();
      if (board.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog well beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
